// ----- rtl/gtns_pkg.sv -----
`timescale 1ns / 1ps
package gtns_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic [12:0] WIDTH_RESET  = 13'd2;
    localparam logic [12:0] HEIGHT_RESET = 13'd2;
    localparam logic [11:0] RADIUS_RESET = 12'd1;

    typedef struct packed {
        logic               cmd;
        logic        [11:0] write_address;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [11:0] query_row;
        logic        [11:0] query_column;
    } t_in;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic        [14:0] norm_z;
        logic               degenerate;
        logic               config_error;
    } t_out;

    // one classified item between front and back
    typedef struct packed {
        logic        is_query;
        logic        cfg_err;
        logic [11:0] wr_addr;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [11:0] row;
        logic [11:0] col;
        logic [11:0] row_before;
        logic [11:0] row_after;
        logic [11:0] col_before;
        logic [11:0] col_after;
    } t_cmd;

endpackage

// ----- rtl/gtns_front.sv -----
`timescale 1ns / 1ps
module gtns_front #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  gtns_pkg::t_in    i_item,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [12:0]      i_cfg_data,
    output logic [12:0]      o_width,
    output logic             o_q_valid,
    input  logic             i_q_pop,
    output gtns_pkg::t_cmd   o_q_head
);
    import gtns_pkg::*;

    logic [12:0] r_width, r_height;
    logic [11:0] r_radius;
    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    logic [25:0] area;
    logic        cfg_bad;
    logic [12:0] row_c, col_c, h_last, w_last;
    logic [13:0] row_up, col_up;
    t_cmd        n_cmd;
    logic        push_ok, pop_ok;

    assign area    = r_width * r_height;
    assign cfg_bad = (r_width < 13'd2) || (r_height < 13'd2) || (r_radius == 12'd0) ||
                     ({6'd0, area} > 32'(MAX_VERTICES));
    assign h_last  = r_height - 13'd1;
    assign w_last  = r_width - 13'd1;

    always_comb begin
        row_c  = ({1'b0, i_item.query_row} > h_last) ? h_last : {1'b0, i_item.query_row};
        col_c  = ({1'b0, i_item.query_column} > w_last) ? w_last : {1'b0, i_item.query_column};
        row_up = {1'b0, row_c} + {2'd0, r_radius};
        col_up = {1'b0, col_c} + {2'd0, r_radius};
        n_cmd.is_query   = (i_item.cmd == CMD_QUERY);
        n_cmd.cfg_err    = cfg_bad;
        n_cmd.wr_addr    = i_item.write_address;
        n_cmd.pos_x      = i_item.pos_x;
        n_cmd.pos_y      = i_item.pos_y;
        n_cmd.pos_z      = i_item.pos_z;
        n_cmd.row        = row_c[11:0];
        n_cmd.col        = col_c[11:0];
        n_cmd.row_before = (row_c > {1'b0, r_radius}) ? 12'(row_c - {1'b0, r_radius}) : 12'd0;
        n_cmd.row_after  = (row_up < {1'b0, h_last}) ? row_up[11:0] : h_last[11:0];
        n_cmd.col_before = (col_c > {1'b0, r_radius}) ? 12'(col_c - {1'b0, r_radius}) : 12'd0;
        n_cmd.col_after  = (col_up < {1'b0, w_last}) ? col_up[11:0] : w_last[11:0];
    end

    assign o_full    = (r_cnt == 2'd2);
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_head  = r_q[r_rp];
    assign o_width   = r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_radius <= RADIUS_RESET;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_RADIUS: r_radius <= i_cfg_data[11:0];
                    default:    ;
                endcase
            end
            if (push_ok) r_wp <= !r_wp;
            if (pop_ok)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= n_cmd;
    end

endmodule

// ----- rtl/gtns_back.sv -----
`timescale 1ns / 1ps
module gtns_back #(
    parameter int MAX_VERTICES     = 4096,
    parameter int COORD_BITS       = 32,
    parameter int NORMAL_FRAC_BITS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  gtns_pkg::t_cmd   i_cmd,
    input  logic [12:0]      i_width,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output gtns_pkg::t_out   o_res
);
    import gtns_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int MAW = $clog2(MAX_VERTICES);
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int CW  = PW + 1;
    localparam int MW  = (CW > 30) ? CW : 31;
    localparam int QB  = F + 1;
    localparam int NW  = 31 + F;
    localparam int QCW = $clog2(QB + 1);
    localparam int LIM = (F >= 15) ? 32767 : ((1 << F) - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DIFF, S_MUL, S_MAG, S_SHIFT,
        S_SQUARE, S_SQRT, S_PREP, S_DIV, S_OUT, S_DONE
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    t_out   r_res;
    logic [2:0]            r_cnt;
    logic [QCW-1:0]        r_dcnt;
    logic [MAW-1:0]        r_addr;
    logic [3*CB-1:0]       r_rd;
    logic [3*CB-1:0]       r_v [4];
    logic [3*CB-1:0]       mem [MAX_VERTICES];
    logic signed [DW-1:0]  r_a [3];
    logic signed [DW-1:0]  r_b [3];
    logic signed [PW-1:0]  r_prod;
    logic signed [CW-1:0]  r_c [3];
    logic [MW-1:0]         r_mag [3];
    logic                  r_neg [3];
    logic [59:0]           r_sq;
    logic [63:0]           r_s, r_sv, r_sr, r_sbit;
    logic [31:0]           r_len;
    logic [32:0]           r_rem [3];
    logic [QB-1:0]         r_lo [3];
    logic [QB-1:0]         r_quo [3];

    logic                  mem_we;
    logic [MAW-1:0]        mem_wa;
    logic [20:0]           wa_ext;
    logic [11:0]           sel_r, sel_c;
    logic [24:0]           addr_p;
    logic signed [DW-1:0]  ma, mb;
    logic [MW-1:0]         orv;
    logic [29:0]           sq_in;
    logic [63:0]           sq_try;
    logic [31:0]           len_c;

    assign wa_ext = {9'd0, i_cmd.wr_addr};
    assign mem_wa = wa_ext[MAW-1:0];
    assign mem_we = (r_state == S_IDLE) && i_q_valid && !i_cmd.is_query &&
                    (wa_ext < 21'(MAX_VERTICES));
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= {i_cmd.pos_z[CB-1:0], i_cmd.pos_y[CB-1:0],
                                    i_cmd.pos_x[CB-1:0]};
        r_rd <= mem[r_addr];
    end

    // neighbor order: column after, column before, row after, row before
    always_comb begin
        case (r_cnt)
            3'd0:    begin sel_r = r_cmd.row;        sel_c = r_cmd.col_after;  end
            3'd1:    begin sel_r = r_cmd.row;        sel_c = r_cmd.col_before; end
            3'd2:    begin sel_r = r_cmd.row_after;  sel_c = r_cmd.col;        end
            default: begin sel_r = r_cmd.row_before; sel_c = r_cmd.col;        end
        endcase
        addr_p = sel_r * i_width + {13'd0, sel_c};
        case (r_cnt)
            3'd0:    begin ma = r_a[1]; mb = r_b[2]; end
            3'd1:    begin ma = r_a[2]; mb = r_b[1]; end
            3'd2:    begin ma = r_a[2]; mb = r_b[0]; end
            3'd3:    begin ma = r_a[0]; mb = r_b[2]; end
            3'd4:    begin ma = r_a[0]; mb = r_b[1]; end
            default: begin ma = r_a[1]; mb = r_b[0]; end
        endcase
        orv    = r_mag[0] | r_mag[1] | r_mag[2];
        sq_in  = (r_cnt == 3'd0) ? r_mag[0][29:0] :
                 (r_cnt == 3'd1) ? r_mag[1][29:0] : r_mag[2][29:0];
        sq_try = r_sr + r_sbit;
        len_c  = (r_sr[31:0] == 32'd0) ? 32'd1 : r_sr[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
            r_dcnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= 3'd0;
                    if (i_q_valid && i_cmd.is_query) begin
                        r_cmd <= i_cmd;
                        r_res <= '{norm_x: 16'd0, norm_y: 16'd0, norm_z: 15'd0,
                                   degenerate: 1'b0, config_error: i_cmd.cfg_err};
                        if (i_cmd.cfg_err) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_cnt < 3'd4) r_addr <= addr_p[MAW-1:0];
                    if (r_cnt >= 3'd2) r_v[2'(r_cnt - 3'd2)] <= r_rd;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) r_state <= S_DIFF;
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= DW'($signed(r_v[0][i*CB +: CB])) -
                                  DW'($signed(r_v[1][i*CB +: CB]));
                        r_b[i] <= DW'($signed(r_v[2][i*CB +: CB])) -
                                  DW'($signed(r_v[3][i*CB +: CB]));
                    end
                    r_cnt   <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // products are registered in r_prod before they are folded into the cross terms
                    if (r_cnt < 3'd6) r_prod <= ma * mb;
                    case (r_cnt)
                        3'd1:    r_c[0] <= {r_prod[PW-1], r_prod};
                        3'd2:    r_c[0] <= r_c[0] - {r_prod[PW-1], r_prod};
                        3'd3:    r_c[1] <= {r_prod[PW-1], r_prod};
                        3'd4:    r_c[1] <= r_c[1] - {r_prod[PW-1], r_prod};
                        3'd5:    r_c[2] <= {r_prod[PW-1], r_prod};
                        3'd6:    r_c[2] <= r_c[2] - {r_prod[PW-1], r_prod};
                        default: ;
                    endcase
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) r_state <= S_MAG;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_c[i][CW-1];
                        r_mag[i] <= MW'(r_c[i][CW-1] ? $unsigned(-r_c[i]) : $unsigned(r_c[i]));
                    end
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (|orv[MW-1:30]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (orv == '0) begin
                        r_res <= '{norm_x: 16'd0, norm_y: 16'd0, norm_z: 15'(LIM),
                                   degenerate: 1'b1, config_error: 1'b0};
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= 3'd0;
                        r_s     <= 64'd0;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    if (r_cnt < 3'd3) r_sq <= sq_in * sq_in;
                    if (r_cnt >= 3'd1) r_s <= r_s + {4'd0, r_sq};
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        r_sv    <= r_s + {4'd0, r_sq};
                        r_sr    <= 64'd0;
                        r_sbit  <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sbit != 64'd0) begin
                        if (r_sv >= sq_try) begin
                            r_sv <= r_sv - sq_try;
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end else begin
                        r_len   <= len_c;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        logic [NW-1:0] num;
                        num = (NW'(r_mag[i][29:0]) << F) + NW'(r_len >> 1);
                        r_rem[i] <= 33'(num[NW-1:QB]);
                        r_lo[i]  <= num[QB-1:0];
                        r_quo[i] <= '0;
                    end
                    if (r_neg[2]) for (int i = 0; i < 3; i++) r_neg[i] <= !r_neg[i];
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        logic [33:0] t;
                        t = {r_rem[i], r_lo[i][QB-1]};
                        if (t >= {2'd0, r_len}) begin
                            r_rem[i] <= 33'(t - {2'd0, r_len});
                            r_quo[i] <= {r_quo[i][QB-2:0], 1'b1};
                        end else begin
                            r_rem[i] <= t[32:0];
                            r_quo[i] <= {r_quo[i][QB-2:0], 1'b0};
                        end
                        r_lo[i] <= r_lo[i] << 1;
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == QCW'(QB - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    logic [15:0] v [3];
                    for (int i = 0; i < 3; i++) begin
                        v[i] = (32'(r_quo[i]) > 32'(LIM)) ? 16'(LIM) : 16'(r_quo[i]);
                        if (r_neg[i]) v[i] = -v[i];
                    end
                    r_res <= '{norm_x: v[0], norm_y: v[1], norm_z: v[2][14:0],
                               degenerate: 1'b0, config_error: 1'b0};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.config_error) |->
            (o_res.norm_x == 16'd0 && o_res.norm_y == 16'd0 &&
             o_res.norm_z == 15'd0 && !o_res.degenerate))
        else $error("config error result carries a normal");

    a_degen_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.degenerate) |->
            (o_res.norm_x == 16'd0 && o_res.norm_y == 16'd0 &&
             o_res.norm_z == 15'(LIM)))
        else $error("degenerate result is not the up vector");

    a_sqrt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |=> (r_state == S_SQRT || r_state == S_PREP))
        else $error("square root left early");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != S_DONE || $past(i_cmd.is_query)))
        else $error("write beat produced a result");

endmodule

// ----- rtl/grid_terrain_normal_stencil.sv -----
`timescale 1ns / 1ps
// Write beats: one per cycle while the back end is idle; the store is written at the edge the
// beat leaves the front queue. While a query is in work the back end takes no new item until
// its result has gone into the result queue; that time is set by the shared multiplier, the
// one-result-bit-per-cycle square root and the restoring dividers.
// Reset (synchronous, active low) restores 2x2 grid, radius 1, and empties both queues;
// the vertex store keeps its contents and is not cleared.
module grid_terrain_normal_stencil #(
    parameter int MAX_VERTICES     = 4096,
    parameter int COORD_BITS       = 32,
    parameter int NORMAL_FRAC_BITS = 15
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  gtns_pkg::t_in   i_item,
    output logic            empty,
    input  logic            pop,
    output gtns_pkg::t_out  o_result,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [12:0]     i_cfg_data
);
    import gtns_pkg::*;

    logic        q_valid, q_pop, res_valid, res_ready;
    t_cmd        q_head;
    t_out        res;
    logic [12:0] width;
    t_out        r_fifo [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push_ok, pop_ok;

    gtns_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_width(width), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_head(q_head)
    );

    gtns_back #(
        .MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS),
        .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_cmd(q_head), .i_width(width),
        .o_res_valid(res_valid), .i_res_ready(res_ready), .o_res(res)
    );

    assign res_ready = (r_cnt != 2'd2);
    assign push_ok   = res_valid && res_ready;
    assign pop_ok    = pop && (r_cnt != 2'd0);
    assign empty     = (r_cnt == 2'd0);
    assign o_result  = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= !r_wp;
            if (pop_ok)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_fifo[r_wp] <= res;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import gtns_pkg::*;

    localparam int STORE_DEPTH   = 4096;
    localparam int FRAC_BITS     = 15;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 300;

    class normal_scoreboard;
        longint      vert[STORE_DEPTH][3];
        logic [12:0] width;
        logic [12:0] height;
        logic [11:0] radius;
        t_out        expected[$];
        int          errors;

        function new();
            width  = WIDTH_RESET;
            height = HEIGHT_RESET;
            radius = RADIUS_RESET;
            errors = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                CFG_WIDTH:  width  = data;
                CFG_HEIGHT: height = data;
                CFG_RADIUS: radius = data[11:0];
                default: ;
            endcase
        endfunction

        function logic signed [127:0] mul_wide(longint p, longint q);
            logic signed [127:0] x;
            logic signed [127:0] y;
            x = p;
            y = q;
            return x * y;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_item(t_in it);
            longint              w, h, rad, row, col, rb, ra, cb, ca;
            longint              a[3], b[3];
            logic signed [127:0] c[3];
            logic        [127:0] mg[3];
            bit                  neg[3];
            longint unsigned     m[3], sq, len, n, lim;
            longint              s;
            int                  bl, k;
            t_out                r;
            w   = width;
            h   = height;
            rad = radius;
            lim = (64'd1 << FRAC_BITS) - 1;
            if (lim > 32767) lim = 32767;
            if (it.cmd == CMD_WRITE) begin
                vert[it.write_address][0] = longint'(it.pos_x);
                vert[it.write_address][1] = longint'(it.pos_y);
                vert[it.write_address][2] = longint'(it.pos_z);
                return;
            end
            r = '0;
            if (w < 2 || h < 2 || rad < 1 || w * h > STORE_DEPTH) begin
                r.config_error = 1'b1;
                expected.push_back(r);
                return;
            end
            row = it.query_row;
            col = it.query_column;
            if (row > h - 1) row = h - 1;
            if (col > w - 1) col = w - 1;
            rb = row > rad ? row - rad : 0;
            ra = row + rad < h - 1 ? row + rad : h - 1;
            cb = col > rad ? col - rad : 0;
            ca = col + rad < w - 1 ? col + rad : w - 1;
            for (int i = 0; i < 3; i++) begin
                a[i] = vert[row * w + ca][i] - vert[row * w + cb][i];
                b[i] = vert[ra * w + col][i] - vert[rb * w + col][i];
            end
            c[0] = mul_wide(a[1], b[2]) - mul_wide(a[2], b[1]);
            c[1] = mul_wide(a[2], b[0]) - mul_wide(a[0], b[2]);
            c[2] = mul_wide(a[0], b[1]) - mul_wide(a[1], b[0]);
            bl = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = c[i] < 0;
                mg[i]  = neg[i] ? -c[i] : c[i];
                for (int j = 0; j < 128; j++)
                    if (mg[i][j] && j + 1 > bl) bl = j + 1;
            end
            if (bl == 0) begin
                r.norm_z     = lim[14:0];
                r.degenerate = 1'b1;
                expected.push_back(r);
                return;
            end
            k  = bl > 30 ? bl - 30 : 0;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = 64'(mg[i] >> k);
                sq   = sq + m[i] * m[i];
            end
            len = root_floor(sq);
            if (len == 0) len = 1;
            // flip toward positive Z
            if (neg[2]) for (int i = 0; i < 3; i++) neg[i] = !neg[i];
            for (int i = 0; i < 3; i++) begin
                n = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
                if (n > lim) n = lim;
                s = neg[i] ? -longint'(n) : longint'(n);
                case (i)
                    0: r.norm_x = s[15:0];
                    1: r.norm_y = s[15:0];
                    default: r.norm_z = s[14:0];
                endcase
            end
            expected.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(t_out got);
            t_out e;
            if (expected.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = expected.pop_front();
            if (got.norm_x !== e.norm_x)
                report($sformatf("norm_x got %0d want %0d", got.norm_x, e.norm_x));
            if (got.norm_y !== e.norm_y)
                report($sformatf("norm_y got %0d want %0d", got.norm_y, e.norm_y));
            if (got.norm_z !== e.norm_z)
                report($sformatf("norm_z got %0d want %0d", got.norm_z, e.norm_z));
            if (got.degenerate !== e.degenerate)
                report($sformatf("degenerate got %b want %b", got.degenerate, e.degenerate));
            if (got.config_error !== e.config_error)
                report($sformatf("config_error got %b want %b",
                                 got.config_error, e.config_error));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in         i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out        o_result;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_WIDTH;
    logic [12:0] i_cfg_data = '0;

    normal_scoreboard sb = new();
    bit hold_req = 1'b0;
    int stall_count = 0;

    grid_terrain_normal_stencil dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we || !i_rst_n) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function int draw_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 10);
    endfunction

    function logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 400)) - 32'd200;
            default: return $urandom;
        endcase
    endfunction

    // result side: pop with random gaps, long hold when asked
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (hold_req) begin
                gap = 3000;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check(o_result);
        end
    end

    task send_item(t_in it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    task drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task write_vertex(int adr, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in it;
        it = '0;
        it.cmd = CMD_WRITE;
        it.write_address = adr[11:0];
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.query_row = $urandom;
        it.query_column = $urandom;
        send_item(it);
    endtask

    task query(int row, int col);
        t_in it;
        it.cmd = CMD_QUERY;
        it.write_address = $urandom;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.query_row = row[11:0];
        it.query_column = col[11:0];
        send_item(it);
    endtask

    // settle in-flight writes, then program all three registers
    task set_grid(int w, int h, int r);
        drain();
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_WIDTH;
        i_cfg_data <= w[12:0];
        @(posedge i_clk);
        sb.set_reg(CFG_WIDTH, w[12:0]);
        i_cfg_idx <= CFG_HEIGHT;
        i_cfg_data <= h[12:0];
        @(posedge i_clk);
        sb.set_reg(CFG_HEIGHT, h[12:0]);
        i_cfg_idx <= CFG_RADIUS;
        i_cfg_data <= r[12:0];
        @(posedge i_clk);
        sb.set_reg(CFG_RADIUS, r[12:0]);
        i_cfg_we <= 1'b0;
    endtask

    task run_phase(int w, int h, int r, int nq, bit hold, bit pause);
        bit valid;
        int sent;
        int cells;
        valid = w >= 2 && h >= 2 && r >= 1 && w * h <= STORE_DEPTH;
        cells = valid ? w * h : STORE_DEPTH;
        set_grid(w, h, r);
        if (valid)
            for (int i = 0; i < cells; i++)
                write_vertex(i, rand_coord(), rand_coord(), rand_coord());
        if (hold) hold_req = 1'b1;
        sent = 0;
        while (sent < nq) begin
            if ($urandom_range(0, 9) < 3) begin
                write_vertex($urandom_range(0, cells - 1),
                             rand_coord(), rand_coord(), rand_coord());
            end else if (valid && $urandom_range(0, 3) != 0) begin
                query($urandom_range(0, h - 1), $urandom_range(0, w - 1));
                sent++;
            end else begin
                query($urandom_range(0, 4095), $urandom_range(0, 4095));
                sent++;
            end
            if (pause && sent == nq / 2) drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flat patch gives the up vector
        for (int i = 0; i < 4; i++) write_vertex(i, 32'd7, 32'd7, 32'd7);
        query(0, 0);
        write_vertex(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        write_vertex(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_vertex(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_vertex(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        write_vertex(4095, 32'hFFFF_FFFF, 32'h0, 32'h1);
        query(0, 0);
        query(0, 1);
        query(1, 0);
        query(1, 1);
        query(4095, 4095);
        query(0, 4095);
        write_vertex(0, 32'd0, 32'd0, 32'd0);
        write_vertex(1, 32'd100, 32'd0, 32'd0);
        write_vertex(2, 32'd0, 32'd100, 32'd0);
        write_vertex(3, 32'd100, 32'd100, 32'd0);
        query(0, 0);
        query(1, 1);

        run_phase(5, 3, 1, 100, 1'b0, 1'b0);
        run_phase(8, 8, 2, 100, 1'b1, 1'b0);
        run_phase(1, 8, 1, 10, 1'b0, 1'b0);
        run_phase(13, 7, 3, 100, 1'b0, 1'b1);
        run_phase(8, 0, 1, 10, 1'b0, 1'b0);
        run_phase(4, 4, 0, 10, 1'b0, 1'b0);
        run_phase(4096, 1, 1, 10, 1'b0, 1'b0);
        run_phase(4096, 4096, 4095, 10, 1'b0, 1'b0);
        run_phase(0, 2, 1, 10, 1'b0, 1'b0);
        run_phase(2, 64, 4095, 40, 1'b0, 1'b0);
        run_phase(6, 6, 4095, 60, 1'b0, 1'b0);
        run_phase(3, 3, 1, 60, 1'b0, 1'b0);
        run_phase(20, 10, 5, 100, 1'b0, 1'b0);
        run_phase(2, 2, 1, 40, 1'b0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
